[rtl/core/sel_pkg.sv]
package sel_pkg;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic MODE_MOD = 1'b0;
   localparam logic MODE_DIV = 1'b1;

   localparam logic [2:0] CSR_PARTITION_MODE = 3'd0;
   localparam logic [2:0] CSR_NUM_SHARDS     = 3'd1;
   localparam logic [2:0] CSR_TOTAL_ROWS     = 3'd2;
   localparam logic [2:0] CSR_ROW_LENGTH     = 3'd3;
   localparam logic [2:0] CSR_CLIP_ENABLE    = 3'd4;
   localparam logic [2:0] CSR_MAX_NORM_LIMIT = 3'd5;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MAP1_GO,
      ST_MAP1_WAIT,
      ST_MAP_MID,
      ST_MAP2_GO,
      ST_MAP2_WAIT,
      ST_MAP_CHK,
      ST_SUM,
      ST_CLIP_CHK,
      ST_NORM_GO,
      ST_NORM_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_EMIT_RD,
      ST_EMIT_MUL,
      ST_EMIT_OUT,
      ST_ERR_OUT
   } state_type;

   typedef struct packed {
      logic partition_mode;
      logic [3:0] num_shards;
      logic [13:0] total_rows;
      logic [6:0] row_length;
      logic clip_enable;
      logic [15:0] max_norm_limit;
   } csr_type;

endpackage

[rtl/core/sharded_embedding_lookup_clip_top.sv]
// Channel   | direction | beat
// req_      | in        | one load or lookup item
// rsp_      | out       | one row element (or one error beat)
// csr_      | in        | one register write
//
// A load writes the table and leaves the sequencer idle. A lookup maps its id with one
// division (two in the div strategy), sums the squares of the row, tests the clip and,
// when clipping, divides and takes a root, then emits one element at a time through the
// single RAM read port; an id at or past total_rows goes straight to its error beat.
// Reset is synchronous and clears control state only; the table is not cleared.
// req_stall is high while a lookup runs; rsp_ stalls hold the output register and the
// sequencer waits on it.
module sharded_embedding_lookup_clip_top
   import sel_pkg::*;
#(
   parameter int MAX_SHARDS         = 8,
   parameter int MAX_ROWS_PER_SHARD = 1024,
   parameter int MAX_ROW_LEN        = 64,
   parameter int ELEM_WIDTH         = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [2:0]  req_load_shard,
   input  logic [9:0]  req_load_row,
   input  logic [5:0]  req_load_col,
   input  logic signed [15:0] req_load_value,
   input  logic [19:0] req_lookup_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_out_value,
   output logic [5:0]  rsp_out_col,
   output logic        rsp_last,
   output logic        rsp_range_error,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int DEPTH = MAX_SHARDS * MAX_ROWS_PER_SHARD * MAX_ROW_LEN;
   localparam int AW    = $clog2(DEPTH);
   localparam int E     = ELEM_WIDTH;
   localparam int SUM_W = 2 * E + $clog2(MAX_ROW_LEN + 1);
   localparam int DVD_W = 64;
   localparam int SW    = (E > 16) ? E + 1 : 17;

   csr_type   csr_ff;
   state_type state_ff, state_in;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.partition_mode <= MODE_MOD;
         csr_ff.num_shards     <= 4'd1;
         csr_ff.total_rows     <= '0;
         csr_ff.row_length     <= 7'd64;
         csr_ff.clip_enable    <= 1'b0;
         csr_ff.max_norm_limit <= 16'd256;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PARTITION_MODE: csr_ff.partition_mode <= csr_wdata[0];
            CSR_NUM_SHARDS:     csr_ff.num_shards     <= csr_wdata[3:0];
            CSR_TOTAL_ROWS:     csr_ff.total_rows     <= csr_wdata[13:0];
            CSR_ROW_LENGTH:     csr_ff.row_length     <= csr_wdata[6:0];
            CSR_CLIP_ENABLE:    csr_ff.clip_enable    <= csr_wdata[0];
            CSR_MAX_NORM_LIMIT: csr_ff.max_norm_limit <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped shard count and row length
   logic [3:0] n_eff;
   logic [6:0] len_eff;
   always_comb begin
      n_eff = csr_ff.num_shards;
      if (csr_ff.num_shards == 4'd0) begin
         n_eff = 4'd1;
      end else if (32'(csr_ff.num_shards) > MAX_SHARDS) begin
         n_eff = 4'(MAX_SHARDS);
      end
      len_eff = csr_ff.row_length;
      if (csr_ff.row_length == 7'd0) begin
         len_eff = 7'd1;
      end else if (32'(csr_ff.row_length) > MAX_ROW_LEN) begin
         len_eff = 7'(MAX_ROW_LEN);
      end
   end

   // ---- input handshake and table writes ----
   logic        req_take;
   logic        load_ok;
   logic [31:0] load_ext;
   logic [AW-1:0] waddr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign load_ok   = (32'(req_load_shard) < MAX_SHARDS) &&
                      (32'(req_load_row) < MAX_ROWS_PER_SHARD) &&
                      (32'(req_load_col) < MAX_ROW_LEN);
   assign load_ext  = {{16{req_load_value[15]}}, req_load_value};
   assign waddr     = AW'((32'(req_load_shard) * MAX_ROWS_PER_SHARD + 32'(req_load_row))
                          * MAX_ROW_LEN + 32'(req_load_col));

   logic [AW-1:0] raddr;
   logic [E-1:0]  rdata;
   logic [AW-1:0] base_ff;
   logic [6:0]    col_ff, col_in;

   assign raddr = base_ff + AW'(col_ff);

   sel_ram #(.WIDTH(E), .DEPTH(DEPTH)) u_table (
      .clock (clock),
      .we    (req_take && (req_operation == OP_LOAD) && load_ok),
      .waddr (waddr),
      .wdata (load_ext[E-1:0]),
      .raddr (raddr),
      .rdata (rdata)
   );

   // magnitude and sign of the element just read
   logic         rd_neg;
   logic [E-1:0] rd_mag;
   assign rd_neg = rdata[E-1];
   assign rd_mag = rd_neg ? (~rdata + 1'b1) : rdata;

   // ---- shared divider and root ----
   logic             div_start;
   logic [DVD_W-1:0] div_dvd;
   logic [SUM_W-1:0] div_dvs;
   logic             div_done;
   logic [DVD_W-1:0] div_quot;
   logic [SUM_W-1:0] div_rem;
   logic             sq_start, sq_done;
   logic [15:0]      sq_root;

   sel_divider #(.DVD_W(DVD_W), .DVS_W(SUM_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   sel_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (div_quot[31:0]),
      .done     (sq_done),
      .root     (sq_root)
   );

   // ---- lookup working registers ----
   logic [13:0]      id_ff;
   logic [13:0]      a_ff;
   logic [3:0]       b_ff;
   logic             lower_ff;
   logic [13:0]      dvd2_ff;
   logic [14:0]      dvs2_ff;
   logic [3:0]       shard_ff;
   logic [13:0]      row_ff;
   logic [31:0]      limsq_ff;
   logic [SUM_W-1:0] acc_ff;
   logic [2*E-1:0]   sq_ff;
   logic             s1_vld_ff, s2_vld_ff;
   logic [16:0]      alpha_ff;
   logic             neg_ff;
   logic [E+16:0]    prod_ff;
   logic [18:0]      bnd;

   assign bnd = 19'(b_ff) * 19'({1'b0, a_ff} + 15'd1);

   always_comb begin
      div_dvd = '0;
      div_dvs = '0;
      case (state_ff)
         ST_MAP1_GO: begin
            div_dvd = (csr_ff.partition_mode == MODE_MOD) ? DVD_W'(id_ff)
                                                          : DVD_W'(csr_ff.total_rows);
            div_dvs = SUM_W'(n_eff);
         end
         ST_MAP2_GO: begin
            div_dvd = DVD_W'(dvd2_ff);
            div_dvs = SUM_W'(dvs2_ff);
         end
         ST_NORM_GO: begin
            div_dvd = {limsq_ff, 32'b0};
            div_dvs = acc_ff;
         end
         default: ;
      endcase
   end

   // ---- output register ----
   logic        out_vld_ff;
   logic [15:0] out_val_ff;
   logic [5:0]  out_col_ff;
   logic        out_last_ff, out_err_ff;
   logic        out_free;
   logic        load_elem, load_err;
   logic [SW-1:0] scaled;
   logic [15:0] sat_val;

   assign out_free = !out_vld_ff || !rsp_stall;

   // round the scaled magnitude, saturate, restore the sign
   always_comb begin
      scaled = SW'((prod_ff + (E+17)'(32768)) >> 16);
      if (neg_ff) begin
         sat_val = (scaled > SW'(32768)) ? 16'h8000 : 16'(~scaled + 1'b1);
      end else begin
         sat_val = (scaled > SW'(32767)) ? 16'h7FFF : scaled[15:0];
      end
   end

   // ---- sequencer ----
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      div_start = 1'b0;
      sq_start  = 1'b0;
      load_elem = 1'b0;
      load_err  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_operation == OP_LOOKUP)) begin
               state_in = (req_lookup_id >= 20'(csr_ff.total_rows)) ? ST_ERR_OUT
                                                                    : ST_MAP1_GO;
            end
         end
         ST_MAP1_GO: begin
            div_start = 1'b1;
            state_in  = ST_MAP1_WAIT;
         end
         ST_MAP1_WAIT: begin
            if (div_done) begin
               state_in = (csr_ff.partition_mode == MODE_MOD) ? ST_MAP_CHK : ST_MAP_MID;
            end
         end
         ST_MAP_MID: state_in = ST_MAP2_GO;
         ST_MAP2_GO: begin
            div_start = 1'b1;
            state_in  = ST_MAP2_WAIT;
         end
         ST_MAP2_WAIT: begin
            if (div_done) begin
               state_in = ST_MAP_CHK;
            end
         end
         ST_MAP_CHK: begin
            col_in   = '0;
            state_in = ((32'(shard_ff) >= MAX_SHARDS) ||
                        (32'(row_ff) >= MAX_ROWS_PER_SHARD)) ? ST_ERR_OUT : ST_SUM;
         end
         ST_SUM: begin
            if (col_ff < len_eff) begin
               col_in = col_ff + 7'd1;
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_CLIP_CHK;
            end
         end
         ST_CLIP_CHK: begin
            col_in   = '0;
            state_in = (csr_ff.clip_enable && (acc_ff > SUM_W'(limsq_ff))) ? ST_NORM_GO
                                                                           : ST_EMIT_RD;
         end
         ST_NORM_GO: begin
            div_start = 1'b1;
            state_in  = ST_NORM_WAIT;
         end
         ST_NORM_WAIT: begin
            if (div_done) begin
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: begin
            sq_start = 1'b1;
            state_in = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (sq_done) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD:  state_in = ST_EMIT_MUL;
         ST_EMIT_MUL: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (out_free) begin
               load_elem = 1'b1;
               col_in    = col_ff + 7'd1;
               state_in  = (col_ff + 7'd1 == len_eff) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_ERR_OUT: begin
            if (out_free) begin
               load_err = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= (state_ff == ST_SUM) && (col_ff < len_eff);
         s2_vld_ff <= s1_vld_ff;
         if (load_elem || load_err) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
      col_ff <= col_in;

      if (req_take) begin
         id_ff    <= req_lookup_id[13:0];
         limsq_ff <= 32'(csr_ff.max_norm_limit) * 32'(csr_ff.max_norm_limit);
         acc_ff   <= '0;
         alpha_ff <= 17'h10000;
      end

      // first division: mod gives shard and row, div gives block size and spill
      if ((state_ff == ST_MAP1_WAIT) && div_done) begin
         shard_ff <= div_rem[3:0];
         row_ff   <= div_quot[13:0];
         a_ff     <= div_quot[13:0];
         b_ff     <= div_rem[3:0];
      end
      if (state_ff == ST_MAP_MID) begin
         lower_ff <= (19'(id_ff) < bnd);
         if (19'(id_ff) < bnd) begin
            dvd2_ff <= id_ff;
            dvs2_ff <= {1'b0, a_ff} + 15'd1;
         end else begin
            dvd2_ff <= 14'(19'(id_ff) - bnd);
            dvs2_ff <= {1'b0, a_ff};
         end
      end
      if ((state_ff == ST_MAP2_WAIT) && div_done) begin
         shard_ff <= lower_ff ? div_quot[3:0] : (b_ff + div_quot[3:0]);
         row_ff   <= div_rem[13:0];
      end
      if (state_ff == ST_MAP_CHK) begin
         base_ff <= AW'((32'(shard_ff) * MAX_ROWS_PER_SHARD + 32'(row_ff)) * MAX_ROW_LEN);
      end

      // square, then accumulate
      if (s1_vld_ff) begin
         sq_ff <= (2*E)'(rd_mag) * (2*E)'(rd_mag);
      end
      if (s2_vld_ff) begin
         acc_ff <= acc_ff + SUM_W'(sq_ff);
      end

      if ((state_ff == ST_ROOT_WAIT) && sq_done) begin
         alpha_ff <= {1'b0, sq_root};
      end
      if (state_ff == ST_EMIT_MUL) begin
         neg_ff  <= rd_neg;
         prod_ff <= (E+17)'(rd_mag) * (E+17)'(alpha_ff);
      end

      if (load_elem) begin
         out_val_ff  <= sat_val;
         out_col_ff  <= col_ff[5:0];
         out_last_ff <= (col_ff + 7'd1 == len_eff);
         out_err_ff  <= 1'b0;
      end else if (load_err) begin
         out_val_ff  <= '0;
         out_col_ff  <= '0;
         out_last_ff <= 1'b1;
         out_err_ff  <= 1'b1;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_out_value   = out_val_ff;
   assign rsp_out_col     = out_col_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_range_error = out_err_ff;

endmodule

[rtl/core/sel_ram.sv]
module sel_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/sel_divider.sv]
// Restoring divider, one quotient bit a cycle.
module sel_divider #(
   parameter int DVD_W = 64,
   parameter int DVS_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DVS_W-1:0] remainder
);

   localparam int CW = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quot_ff, quot_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[DVD_W-1]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = DVS_W'(trial - {1'b0, dvs_ff});
            quot_in = {quot_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DVS_W-1:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

[rtl/core/sel_isqrt.sv]
// Digit-recurrence square root, two radicand bits a cycle, rounded to nearest.
module sel_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] radicand,
   output logic        done,
   output logic [15:0] root
);

   logic [31:0] rad_ff, rad_in;
   logic [19:0] rem_ff, rem_in;
   logic [15:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [19:0] rem_sh, trial;
   logic [16:0] rounded;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[17:0], rad_ff[31:30]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[29:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[14:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // round up when the remainder passes the root, saturate at full scale
   always_comb begin
      rounded = {1'b0, root_ff};
      if (rem_ff > {4'b0, root_ff}) begin
         rounded = {1'b0, root_ff} + 17'd1;
      end
   end

   assign done = done_ff;
   assign root = rounded[16] ? 16'hFFFF : rounded[15:0];

endmodule

[rtl/core/sel_checker.sv]
module sel_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_out_value,
   input logic [5:0]  rsp_out_col,
   input logic        rsp_last,
   input logic        rsp_range_error
);

   // an error beat closes its item alone
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_last)
      else $error("error beat without last");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> (rsp_out_value == 16'd0) && (rsp_out_col == 6'd0))
      else $error("error beat carries data");

   // hold the input side while a row is still being emitted
   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken mid-row");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_value) && $stable(rsp_out_col))
      else $error("stalled beat changed");

endmodule

bind sharded_embedding_lookup_clip_top sel_checker u_sel_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_value   (rsp_out_value),
   .rsp_out_col     (rsp_out_col),
   .rsp_last        (rsp_last),
   .rsp_range_error (rsp_range_error)
);

[tb/tb_top.sv]
module tb_top;
   import sel_pkg::*;

   localparam int SHARDS    = 8;
   localparam int ROWS      = 1024;
   localparam int ROW_LEN   = 64;
   localparam int DEPTH     = SHARDS * ROWS * ROW_LEN;
   localparam int CYCLE_CAP = 4000000;
   localparam int SETTLE    = 20;
   localparam int ITEMS     = 480;

   typedef struct {
      logic signed [15:0] value;
      logic [5:0]         col;
      logic               last;
      logic               err;
   } beat_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #10 clock = ~clock;

   // block inputs, all known from time zero
   logic               req_valid      = 1'b0;
   logic               req_operation  = OP_LOAD;
   logic [2:0]         req_load_shard = '0;
   logic [9:0]         req_load_row   = '0;
   logic [5:0]         req_load_col   = '0;
   logic signed [15:0] req_load_value = '0;
   logic [19:0]        req_lookup_id  = '0;
   logic               rsp_stall      = 1'b0;
   logic               csr_wr_en      = 1'b0;
   logic [2:0]         csr_index      = '0;
   logic [15:0]        csr_wdata      = '0;

   logic               req_stall;
   logic               rsp_valid;
   logic signed [15:0] rsp_out_value;
   logic [5:0]         rsp_out_col;
   logic               rsp_last;
   logic               rsp_range_error;

   sharded_embedding_lookup_clip_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_load_shard(req_load_shard),
      .req_load_row(req_load_row), .req_load_col(req_load_col),
      .req_load_value(req_load_value), .req_lookup_id(req_lookup_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_value(rsp_out_value), .rsp_out_col(rsp_out_col),
      .rsp_last(rsp_last), .rsp_range_error(rsp_range_error),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the register file, masked to register widths
   logic        cfg_mode      = MODE_MOD;
   logic [3:0]  cfg_shards    = 4'd1;
   logic [13:0] cfg_rows      = '0;
   logic [6:0]  cfg_len       = 7'd64;
   logic        cfg_clip      = 1'b0;
   logic [15:0] cfg_limit     = 16'd256;

   // shadow of the table; entries are marked once loaded
   logic signed [15:0] table_shadow [DEPTH];
   bit                 loaded [DEPTH];

   beat_type expected_beats [$];
   int    mismatches = 0;
   int    cycles     = 0;
   int    burst_left = 0;
   int    items_sent = 0;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic int unsigned shards_in_use();
      if (cfg_shards == 0) return 1;
      if (cfg_shards > SHARDS) return SHARDS;
      return cfg_shards;
   endfunction

   function automatic int unsigned elems_per_row();
      if (cfg_len == 0) return 1;
      if (cfg_len > ROW_LEN) return ROW_LEN;
      return cfg_len;
   endfunction

   // map a global id; return 1 when it lands inside the table
   function automatic bit map_id(input int unsigned id, output int unsigned shard,
                                 output int unsigned row);
      int unsigned n, a, b;
      n = shards_in_use();
      if (cfg_mode == MODE_MOD) begin
         shard = id % n;
         row   = id / n;
      end else begin
         a = cfg_rows / n;
         b = cfg_rows % n;
         if (id < b * (a + 1)) begin
            shard = id / (a + 1);
            row   = id % (a + 1);
         end else if (a != 0) begin
            shard = b + (id - b * (a + 1)) / a;
            row   = (id - b * (a + 1)) % a;
         end else begin
            shard = n;
            row   = ROWS;
         end
      end
      return (id < cfg_rows) && (shard < SHARDS) && (row < ROWS);
   endfunction

   function automatic longint unsigned root_rounded(input longint unsigned q);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= q) r = t;
      end
      if (q - r * r > r) r++;
      return r;
   endfunction

   task automatic predict_row_beats(input int unsigned id);
      int unsigned      shard, row, len, base;
      longint unsigned  sumsq, lim, alpha, m;
      longint           e;
      bit               clip;
      beat_type         b;
      if (!map_id(id, shard, row)) begin
         b.value = '0; b.col = '0; b.last = 1'b1; b.err = 1'b1;
         expected_beats.push_back(b);
         return;
      end
      len   = elems_per_row();
      base  = (shard * ROWS + row) * ROW_LEN;
      sumsq = 0;
      for (int c = 0; c < len; c++) begin
         e = table_shadow[base + c];
         m = (e < 0) ? -e : e;
         sumsq += m * m;
      end
      lim   = cfg_limit;
      alpha = 65536;
      clip  = cfg_clip && (sumsq > lim * lim);
      if (clip) begin
         alpha = root_rounded(((lim * lim) << 32) / sumsq);
         if (alpha > 65535) alpha = 65535;
      end
      for (int c = 0; c < len; c++) begin
         e = table_shadow[base + c];
         m = (e < 0) ? -e : e;
         if (clip) m = (m * alpha + 32768) >> 16;
         if (e < 0) begin
            if (m > 32768) m = 32768;
            b.value = 16'(-m);
         end else begin
            if (m > 32767) m = 32767;
            b.value = 16'(m);
         end
         b.col  = 6'(c);
         b.last = (c + 1 == len);
         b.err  = 1'b0;
         expected_beats.push_back(b);
      end
   endtask

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   // Send one request beat: insert a random gap between bursts, drive on the
   // falling edge, hold until accepted, then update the shadow / predict.
   task automatic send_beat(input logic op, input int unsigned shard,
                            input int unsigned row, input int unsigned col,
                            input logic signed [15:0] value, input int unsigned id);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_load_shard <= 3'(shard);
      req_load_row   <= 10'(row);
      req_load_col   <= 6'(col);
      req_load_value <= value;
      req_lookup_id  <= 20'(id);
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (op == OP_LOAD) begin
         table_shadow[(shard * ROWS + row) * ROW_LEN + col] = value;
         loaded[(shard * ROWS + row) * ROW_LEN + col] = 1'b1;
      end else begin
         predict_row_beats(id);
      end
   endtask

   task automatic load_elem(input int unsigned shard, input int unsigned row,
                            input int unsigned col, input logic signed [15:0] value);
      send_beat(OP_LOAD, shard, row, col, value, $urandom_range(0, 20'hFFFFF));
   endtask

   // Fill any unloaded element of the target row first, so no lookup ever
   // reads an entry that was never written.
   task automatic lookup_id(input int unsigned id);
      int unsigned shard, row;
      if (map_id(id, shard, row)) begin
         for (int c = 0; c < elems_per_row(); c++)
            if (!loaded[(shard * ROWS + row) * ROW_LEN + c])
               load_elem(shard, row, c, 16'($urandom_range(0, 16'hFFFF)));
      end
      send_beat(OP_LOOKUP, $urandom_range(0, 7), $urandom_range(0, 1023),
                $urandom_range(0, 63), 16'($urandom_range(0, 16'hFFFF)), id);
   endtask

   // drop valid, drain every expected beat and let the block go idle
   task automatic settle();
      @(negedge clock);
      req_valid  <= 1'b0;
      burst_left = 0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input int unsigned data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_PARTITION_MODE: cfg_mode   = data[0];
         CSR_NUM_SHARDS:     cfg_shards = data[3:0];
         CSR_TOTAL_ROWS:     cfg_rows   = data[13:0];
         CSR_ROW_LENGTH:     cfg_len    = data[6:0];
         CSR_CLIP_ENABLE:    cfg_clip   = data[0];
         CSR_MAX_NORM_LIMIT: cfg_limit  = data[15:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic mode, input int unsigned n, input int unsigned rows,
                            input int unsigned len, input logic clip, input int unsigned lim);
      settle();
      write_reg(CSR_PARTITION_MODE, mode);
      write_reg(CSR_NUM_SHARDS, n);
      write_reg(CSR_TOTAL_ROWS, rows);
      write_reg(CSR_ROW_LENGTH, len);
      write_reg(CSR_CLIP_ENABLE, clip);
      write_reg(CSR_MAX_NORM_LIMIT, lim);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------
   task automatic test_default_registers();
      // total_rows resets to zero: any id is out of range
      lookup_id(0);
      lookup_id(20'hFFFFF);
   endtask

   task automatic test_value_extremes();
      configure(MODE_MOD, 8, 8192, 64, 1'b0, 256);
      // full-scale elements at the far corner of the table
      load_elem(7, 1023, 63, 16'sh7FFF);
      load_elem(7, 1023, 0, -16'sd32768);
      lookup_id(1023 * 8 + 7);
      lookup_id(8192);          // first id past the bound
   endtask

   task automatic test_clipping();
      configure(MODE_MOD, 1, 4, 4, 1'b1, 0);
      for (int c = 0; c < 4; c++) load_elem(0, 0, c, (c & 1) ? -16'sd300 : 16'sd700);
      for (int c = 0; c < 4; c++) load_elem(0, 1, c, 16'sd0);
      lookup_id(0);             // limit zero scales every element to zero
      lookup_id(1);             // all-zero row never clips
      configure(MODE_MOD, 1, 4, 4, 1'b1, 16'hFFFF);
      lookup_id(0);             // limit above the norm
      configure(MODE_MOD, 1, 4, 4, 1'b1, 500);
      lookup_id(0);
   endtask

   task automatic test_mapping_corners();
      configure(MODE_MOD, 1, 8192, 1, 1'b0, 256);
      lookup_id(5000);          // row beyond the shard depth
      configure(MODE_DIV, 8, 3, 2, 1'b0, 256);
      lookup_id(2);             // fewer rows than shards
      lookup_id(3);
      configure(MODE_DIV, 3, 10, 3, 1'b1, 100);
      lookup_id(3);             // last id of the wide blocks
      lookup_id(4);
      lookup_id(9);
      configure(MODE_MOD, 0, 20, 0, 1'b0, 256);
      lookup_id(7);             // zero shards and zero length clamp to one
      configure(MODE_MOD, 15, 100, 127, 1'b0, 256);
      lookup_id(99);            // oversized shards and length clamp to maximum
   endtask

   // share what is left of the item budget evenly over the phases
   task automatic test_random_phases();
      int unsigned n, rows, len, lim, id;
      int          quota;
      for (int ph = 0; ph < 7; ph++) begin
         n    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         rows = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8192) : $urandom_range(1, 200);
         len  = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 12);
         lim  = $urandom_range(0, 1) ? $urandom_range(0, 3000) : $urandom_range(0, 16'hFFFF);
         configure($urandom_range(0, 1), n, rows, len, $urandom_range(0, 1), lim);
         quota = (items_sent < ITEMS) ? items_sent + (ITEMS - items_sent) / (7 - ph)
                                      : items_sent;
         while (items_sent < quota) begin
            if ($urandom_range(0, 9) < 3) begin
               load_elem($urandom_range(0, 7), $urandom_range(0, 1023),
                         $urandom_range(0, 63), 16'($urandom_range(0, 16'hFFFF)));
            end else begin
               case ($urandom_range(0, 9))
                  0:       id = $urandom_range(0, 20'hFFFFF);
                  1:       id = cfg_rows + $urandom_range(0, 2);
                  default: id = (cfg_rows == 0) ? 0 : $urandom_range(0, cfg_rows - 1);
               endcase
               lookup_id(id);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------
   // result stall pattern: stretches of none, light and heavy stalling
   // ---------------------------------------------------------------
   int stall_mode = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 300);
      end
      stall_left--;
      case (stall_mode)
         1:       rsp_stall <= ($urandom_range(0, 9) < 3);
         2:       rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= 1'b0;
      endcase
   end

   // ---------------------------------------------------------------
   // result checker: compare each accepted beat with the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      beat_type b;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: value %0d col %0d last %0b err %0b",
                        rsp_out_value, rsp_out_col, rsp_last, rsp_range_error);
         end else begin
            b = expected_beats.pop_front();
            if (rsp_out_value !== b.value || rsp_out_col !== b.col ||
                rsp_last !== b.last || rsp_range_error !== b.err) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp value %0d col %0d last %0b err %0b, got %0d %0d %0b %0b",
                           b.value, b.col, b.last, b.err,
                           rsp_out_value, rsp_out_col, rsp_last, rsp_range_error);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_registers();
      test_value_extremes();
      test_clipping();
      test_mapping_corners();
      test_random_phases();
      settle();
      repeat (200) @(posedge clock);
      // leftover expectations count as failures
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/sel_pkg.sv
rtl/core/sel_ram.sv
rtl/core/sel_divider.sv
rtl/core/sel_isqrt.sv
rtl/core/sharded_embedding_lookup_clip_top.sv
rtl/core/sel_checker.sv
tb/tb_top.sv
